FILE: rtl/cfcu_pkg.sv
// shared types and constants of the flags and condition unit
`timescale 1ns / 1ps

package cfcu_pkg;

  localparam int unsigned FLAGS_W = 32;

  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_RSV = 1;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_AF = 4;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_OF = 11;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 32'h0000_0002;

  localparam logic [31:0] MASK_BYTE = 32'h0000_00FF;
  localparam logic [31:0] MASK_WORD = 32'h0000_FFFF;
  localparam logic [31:0] MASK_DWORD = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_BYTE = 32'h0000_0080;
  localparam logic [31:0] SIGN_WORD = 32'h0000_8000;
  localparam logic [31:0] SIGN_DWORD = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_SET_RESULT = 2'd0,
    OP_CMP_SIGNED = 2'd1,
    OP_CMP_UNSIGNED = 2'd2,
    OP_CHECK_COND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_DWORD = 2'd2,
    SIZE_DWORD_ALT = 2'd3
  } size_t;

  typedef enum logic [3:0] {
    CC_Z = 4'd0,
    CC_NZ = 4'd1,
    CC_C = 4'd2,
    CC_NC = 4'd3,
    CC_BE = 4'd4,
    CC_A = 4'd5,
    CC_S = 4'd6,
    CC_NS = 4'd7,
    CC_BE_ALT = 4'd8,
    CC_A_ALT = 4'd9,
    CC_L = 4'd10,
    CC_GE = 4'd11,
    CC_LE = 4'd12,
    CC_G = 4'd13,
    CC_NZ_ALT = 4'd14,
    CC_Z_ALT = 4'd15
  } cond_t;

endpackage

FILE: rtl/cpu_flags_and_condition_unit.sv
// flags register and condition evaluation unit
// a request passes the input register, then the result register; the flags update is a single
// subtract and mux pass; throughput: one request per cycle while out_ready is high
// reset (rst_n low, synchronous): both stages empty, flags word back to 0x00000002
`timescale 1ns / 1ps

module cpu_flags_and_condition_unit
  import cfcu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic [1:0]  in_operand_size,
  input  logic [3:0]  in_condition_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_flags_word,
  output logic        out_condition_true
);

  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [31:0]        s1_a_r;
  logic [31:0]        s1_b_r;
  size_t              s1_size_r;
  cond_t              s1_cc_r;

  logic [FLAGS_W-1:0] flags_r;
  logic [FLAGS_W-1:0] flags_nxt;
  logic               cond_nxt;

  logic               out_valid_r;
  logic [31:0]        out_flags_r;
  logic               out_cond_r;

  logic               advance;
  logic [31:0]        mask;
  logic [31:0]        sign;
  logic [31:0]        a_m;
  logic [31:0]        b_m;
  logic [32:0]        diff;
  logic [31:0]        r_m;
  logic [31:0]        v_m;
  logic               zf;
  logic               sf;
  logic               pf;
  logic               cond_eval;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op_r   <= op_t'(in_operation);
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_size_r <= size_t'(in_operand_size);
      s1_cc_r   <= cond_t'(in_condition_code);
    end
  end

  always_comb begin
    case (s1_size_r)
      SIZE_BYTE: begin
        mask = MASK_BYTE;
        sign = SIGN_BYTE;
      end
      SIZE_WORD: begin
        mask = MASK_WORD;
        sign = SIGN_WORD;
      end
      default: begin
        mask = MASK_DWORD;
        sign = SIGN_DWORD;
      end
    endcase
  end

  assign a_m  = s1_a_r & mask;
  assign b_m  = s1_b_r & mask;
  assign diff = {1'b0, a_m} - {1'b0, b_m};
  assign r_m  = diff[31:0] & mask;
  assign v_m  = (s1_op_r == OP_SET_RESULT) ? a_m : r_m;
  assign zf   = (v_m == 32'd0);
  assign sf   = |(v_m & sign);
  assign pf   = ~^v_m[7:0];

  always_comb begin
    case (s1_cc_r)
      CC_Z:      cond_eval = flags_r[FLAG_ZF];
      CC_NZ:     cond_eval = !flags_r[FLAG_ZF];
      CC_C:      cond_eval = flags_r[FLAG_CF];
      CC_NC:     cond_eval = !flags_r[FLAG_CF];
      CC_BE:     cond_eval = flags_r[FLAG_ZF] || flags_r[FLAG_CF];
      CC_A:      cond_eval = !(flags_r[FLAG_ZF] || flags_r[FLAG_CF]);
      CC_S:      cond_eval = flags_r[FLAG_SF];
      CC_NS:     cond_eval = !flags_r[FLAG_SF];
      CC_BE_ALT: cond_eval = flags_r[FLAG_ZF] || flags_r[FLAG_CF];
      CC_A_ALT:  cond_eval = !(flags_r[FLAG_ZF] || flags_r[FLAG_CF]);
      CC_L:      cond_eval = flags_r[FLAG_SF] != flags_r[FLAG_OF];
      CC_GE:     cond_eval = flags_r[FLAG_SF] == flags_r[FLAG_OF];
      CC_LE:     cond_eval = flags_r[FLAG_ZF] || (flags_r[FLAG_SF] != flags_r[FLAG_OF]);
      CC_G:      cond_eval = !flags_r[FLAG_ZF] && (flags_r[FLAG_SF] == flags_r[FLAG_OF]);
      CC_NZ_ALT: cond_eval = !flags_r[FLAG_ZF];
      default:   cond_eval = flags_r[FLAG_ZF];
    endcase
  end

  always_comb begin
    flags_nxt = flags_r;
    cond_nxt  = 1'b0;
    case (s1_op_r)
      OP_SET_RESULT: begin
        flags_nxt[FLAG_CF] = 1'b0;
        flags_nxt[FLAG_OF] = 1'b0;
        flags_nxt[FLAG_AF] = 1'b0;
        flags_nxt[FLAG_ZF] = zf;
        flags_nxt[FLAG_SF] = sf;
        flags_nxt[FLAG_PF] = pf;
      end
      OP_CMP_SIGNED, OP_CMP_UNSIGNED: begin
        flags_nxt[FLAG_ZF] = zf;
        flags_nxt[FLAG_SF] = sf;
        flags_nxt[FLAG_PF] = pf;
        flags_nxt[FLAG_CF] = diff[32];
        flags_nxt[FLAG_OF] = (s1_op_r == OP_CMP_SIGNED) && (|((a_m ^ b_m) & (a_m ^ r_m) & sign));
      end
      default: begin
        cond_nxt = cond_eval;
      end
    endcase
  end

  // flags state and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= FLAGS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_flags_r <= flags_nxt;
      out_cond_r  <= cond_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_flags_word     = out_flags_r;
  assign out_condition_true = out_cond_r;

  // reserved bit one never drops
  a_rsv_bit: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[FLAG_RSV])
    else $error("reserved flag bit cleared");

  // a zero result cannot be negative or borrow
  a_zf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(flags_r[FLAG_ZF] && (flags_r[FLAG_SF] || flags_r[FLAG_CF])))
    else $error("zf set together with sf or cf");

  // condition check leaves the flags alone
  a_check_stable: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_op_r == OP_CHECK_COND) |=> $stable(flags_r))
    else $error("condition check changed flags");

  // only a condition check can report true
  a_cond_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_op_r != OP_CHECK_COND) |=> !out_cond_r)
    else $error("condition_true set by a non-check request");

  // result register mirrors the flags state
  a_out_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_flags_r == flags_r))
    else $error("result flags differ from flags state");

endmodule

FILE: dv/tb_cpu_flags_and_condition_unit.sv
// testbench for the flags and condition unit: random and directed requests against a flags predictor
`timescale 1ns / 1ps

module tb_cpu_flags_and_condition_unit;
  import cfcu_pkg::*;

  typedef struct packed {
    logic [31:0] flags;
    logic        cond;
  } flags_result_t;

  class flags_tracker;
    logic [31:0]   flags_now;
    flags_result_t expected_q[$];
    int            errors;
    int            compared;
    int            op_count[4];

    function new();
      flags_now = FLAGS_RESET;
      errors = 0;
      compared = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void load_zsp(logic [31:0] v, logic [31:0] sign);
      flags_now[FLAG_ZF] = (v == 32'd0);
      flags_now[FLAG_SF] = |(v & sign);
      flags_now[FLAG_PF] = ~^v[7:0];
    endfunction

    function logic cond_holds(cond_t cc);
      logic zf, sf, of, cf;
      zf = flags_now[FLAG_ZF];
      sf = flags_now[FLAG_SF];
      of = flags_now[FLAG_OF];
      cf = flags_now[FLAG_CF];
      case (cc)
        CC_Z, CC_Z_ALT: return zf;
        CC_NZ, CC_NZ_ALT: return !zf;
        CC_C: return cf;
        CC_NC: return !cf;
        CC_BE, CC_BE_ALT: return zf | cf;
        CC_A, CC_A_ALT: return !(zf | cf);
        CC_S: return sf;
        CC_NS: return !sf;
        CC_L: return sf != of;
        CC_GE: return sf == of;
        CC_LE: return zf | (sf != of);
        default: return !zf & (sf == of);
      endcase
    endfunction

    function void note_request(op_t op, logic [31:0] a_in, logic [31:0] b_in,
                               logic [1:0] size, cond_t cc);
      logic [31:0]   mask, sign, a, b, r;
      flags_result_t res;
      case (size)
        SIZE_BYTE: begin
          mask = MASK_BYTE;
          sign = SIGN_BYTE;
        end
        SIZE_WORD: begin
          mask = MASK_WORD;
          sign = SIGN_WORD;
        end
        default: begin
          mask = MASK_DWORD;
          sign = SIGN_DWORD;
        end
      endcase
      a = a_in & mask;
      b = b_in & mask;
      res.cond = 1'b0;
      op_count[op]++;
      case (op)
        OP_SET_RESULT: begin
          load_zsp(a, sign);
          flags_now[FLAG_CF] = 1'b0;
          flags_now[FLAG_OF] = 1'b0;
          flags_now[FLAG_AF] = 1'b0;
        end
        OP_CMP_SIGNED, OP_CMP_UNSIGNED: begin
          r = (a - b) & mask;
          load_zsp(r, sign);
          flags_now[FLAG_CF] = (a < b);
          flags_now[FLAG_OF] = (op == OP_CMP_SIGNED) && |((a ^ b) & (a ^ r) & sign);
        end
        default: res.cond = cond_holds(cc);
      endcase
      res.flags = flags_now;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] flags, logic cond);
      flags_result_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing expected: flags %h cond %b", $realtime, flags, cond);
        return;
      end
      exp_res = expected_q.pop_front();
      compared++;
      if (flags !== exp_res.flags || cond !== exp_res.cond) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: flags exp %h got %h, cond exp %b got %b",
                   $realtime, exp_res.flags, flags, exp_res.cond, cond);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = 2'd0;
  logic [31:0] in_operand_a = 32'd0;
  logic [31:0] in_operand_b = 32'd0;
  logic [1:0]  in_operand_size = 2'd0;
  logic [3:0]  in_condition_code = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_flags_word;
  logic        out_condition_true;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int longest_hold = 0;

  flags_tracker flags_sb = new();

  cpu_flags_and_condition_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .in_operand_size   (in_operand_size),
    .in_condition_code (in_condition_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_flags_word    (out_flags_word),
    .out_condition_true(out_condition_true)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        flags_sb.note_request(op_t'(in_operation), in_operand_a, in_operand_b,
                              in_operand_size, cond_t'(in_condition_code));
      if (out_valid && out_ready)
        flags_sb.check_result(out_flags_word, out_condition_true);
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
    end
  end

  task automatic send_request(input op_t op, input logic [31:0] a, input logic [31:0] b,
                              input logic [1:0] size, input cond_t cc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    in_operand_size <= size;
    in_condition_code <= cc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return {8'($urandom_range(255)), 24'h000080};
      3: return {8'($urandom_range(255)), 24'h00007F};
      4: return {16'($urandom), 16'h8000};
      5: return {16'($urandom), 16'h7FFF};
      6: return 32'h8000_0000;
      7: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] a, b;
    a = pick_operand();
    b = ($urandom_range(9) == 0) ? a : pick_operand();
    send_request(op_t'($urandom_range(3)), a, b, 2'($urandom_range(3)),
                 cond_t'($urandom_range(15)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_NZ);
    send_request(OP_SET_RESULT, 32'hFFFF_FF00, 32'd0, SIZE_BYTE, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_Z);
    send_request(OP_SET_RESULT, 32'h1234_5680, 32'd0, SIZE_BYTE, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_S);
    send_request(OP_SET_RESULT, 32'h8000_0000, 32'd0, SIZE_DWORD, CC_Z);
    send_request(OP_CMP_SIGNED, 32'h0000_0080, 32'h0000_0001, SIZE_BYTE, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_L);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_LE);
    send_request(OP_CMP_SIGNED, 32'h0000_007F, 32'h0000_00FF, SIZE_BYTE, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_GE);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_A);
    send_request(OP_CMP_UNSIGNED, 32'hABCD_8000, 32'h0000_0001, SIZE_WORD, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_G);
    send_request(OP_CMP_SIGNED, 32'h8000_0000, 32'h0000_0001, SIZE_DWORD, CC_Z);
    send_request(OP_CMP_SIGNED, 32'h7FFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD_ALT, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_C);
    send_request(OP_CMP_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_DWORD, CC_Z);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_BE_ALT);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_A_ALT);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_NZ_ALT);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_Z_ALT);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_NC);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_NS);
    send_request(OP_CHECK_COND, 32'd0, 32'd0, SIZE_BYTE, CC_BE);

    // full rate, then a long hold-off on the result side while requests keep coming
    repeat (300) send_random();
    longest_hold = 300;
    hold_cycles = longest_hold;
    repeat (60) send_random();

    send_idle_pct = 83;
    repeat (360) send_random();

    send_idle_pct = 0;
    recv_stall_pct = 83;
    repeat (360) send_random();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    repeat (370) send_random();

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (flags_sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d results compared; set %0d, signed cmp %0d, unsigned cmp %0d, cond %0d",
             flags_sb.compared, flags_sb.op_count[OP_SET_RESULT],
             flags_sb.op_count[OP_CMP_SIGNED], flags_sb.op_count[OP_CMP_UNSIGNED],
             flags_sb.op_count[OP_CHECK_COND]);
    $display("idle and stall mixes plus a %0d cycle output hold-off; %0d mismatches",
             longest_hold, flags_sb.errors);
    if (flags_sb.errors == 0 && flags_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
